@@ sv/rtcd_pkg.sv @@
// rtcd_pkg: shared types and constants for the two-centroid rgb distance block
// no dependencies; used by rtcd_sumsq and rgb_two_centroid_distance_top
`default_nettype none

package rtcd_pkg;

    // channel width of pixels and centroids
    localparam int CH_W = 8;

    // sum of three squared 8-bit differences, 3 * 255^2 = 195075 fits in 18 bits
    localparam int SUM_W = 18;

    // output distance width and its saturation value
    localparam int OUT_W = 17;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // configuration register indexes
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FIRST_RED    = 3'd0,
        REG_FIRST_GREEN  = 3'd1,
        REG_FIRST_BLUE   = 3'd2,
        REG_SECOND_RED   = 3'd3,
        REG_SECOND_GREEN = 3'd4,
        REG_SECOND_BLUE  = 3'd5
    } cfg_reg_t;

    // one color: a pixel or a centroid
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

endpackage

`default_nettype wire

@@ sv/rgb_two_centroid_distance_top.sv @@
// rgb_two_centroid_distance_top: euclidean distance of an rgb pixel to two centroids
// depends on rtcd_pkg, rtcd_sumsq and rtcd_isqrt
`default_nettype none

// One pixel word in, one distance word out. For each pixel the block gives the
// distance to the first and to the second centroid as floor(sqrt(sum * 4^FRAC_BITS)),
// an unsigned 17-bit value with FRAC_BITS fractional bits, saturated at 131071.
// The last-pixel marker rides along unchanged. The block takes a new pixel in every
// cycle; the whole datapath is one pipeline that only holds when a finished word
// waits at the output with out_stall high. From input to output register a pixel
// passes the difference, square and sum stages, one square root stage per root
// bit, and the output register. Centroid registers are written through wr_en /
// wr_index / wr_data; the user must write them only while no pixel is in flight,
// as the block itself does not enforce it; writes to an index past the six
// registers are dropped.

module rgb_two_centroid_distance_top
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // configuration write port
    input  wire logic                          wr_en,
    input  wire logic [rtcd_pkg::REG_IDX_W-1:0] wr_index,
    input  wire logic [rtcd_pkg::CH_W-1:0]     wr_data,

    // pixel input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rtcd_pkg::CH_W-1:0]     red,
    input  wire logic [rtcd_pkg::CH_W-1:0]     green,
    input  wire logic [rtcd_pkg::CH_W-1:0]     blue,
    input  wire logic                          final_pixel,

    // distance output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [rtcd_pkg::OUT_W-1:0]         dist_first,
    output logic [rtcd_pkg::OUT_W-1:0]         dist_second,
    output logic                               final_out
);

    localparam int SUM_W  = rtcd_pkg::SUM_W;
    localparam int OUT_W  = rtcd_pkg::OUT_W;
    localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int EXT_W  = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;

    // centroid registers
    rtcd_pkg::rgb_t first_reg, first_next;
    rtcd_pkg::rgb_t second_reg, second_next;

    // pipeline advance: everything moves unless a word is stuck at the output
    logic en;

    rtcd_pkg::rgb_t pixel;

    logic               ss_valid, ss_final;
    logic [SUM_W-1:0]   ss_sum_a, ss_sum_b;
    logic [RAD_W-1:0]   rad_a, rad_b;

    logic               sq_valid, sq_final;
    logic [ROOT_W-1:0]  sq_root_a, sq_root_b;
    logic [EXT_W-1:0]   ext_a, ext_b;

    // output register
    logic               out_valid_reg;
    logic [OUT_W-1:0]   dist_first_reg, dist_first_next;
    logic [OUT_W-1:0]   dist_second_reg, dist_second_next;
    logic               final_reg;

    // config decode, out-of-range index writes nothing
    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                rtcd_pkg::REG_FIRST_RED:    first_next.red    = wr_data;
                rtcd_pkg::REG_FIRST_GREEN:  first_next.green  = wr_data;
                rtcd_pkg::REG_FIRST_BLUE:   first_next.blue   = wr_data;
                rtcd_pkg::REG_SECOND_RED:   second_next.red   = wr_data;
                rtcd_pkg::REG_SECOND_GREEN: second_next.green = wr_data;
                rtcd_pkg::REG_SECOND_BLUE:  second_next.blue  = wr_data;
                default:
                begin
                    first_next  = first_reg;
                    second_next = second_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    assign pixel.red   = red;
    assign pixel.green = green;
    assign pixel.blue  = blue;

    // differences, squares and sums
    rtcd_sumsq u_sumsq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_final  (final_pixel),
        .pixel     (pixel),
        .cent_a    (first_reg),
        .cent_b    (second_reg),
        .out_valid (ss_valid),
        .out_final (ss_final),
        .sum_a     (ss_sum_a),
        .sum_b     (ss_sum_b)
    );

    // scale by 4^FRAC_BITS so the root carries FRAC_BITS fraction bits
    assign rad_a = RAD_W'(RAD_W'(ss_sum_a) << (2 * FRAC_BITS));
    assign rad_b = RAD_W'(RAD_W'(ss_sum_b) << (2 * FRAC_BITS));

    rtcd_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ss_valid),
        .in_final  (ss_final),
        .rad_a     (rad_a),
        .rad_b     (rad_b),
        .out_valid (sq_valid),
        .out_final (sq_final),
        .root_a    (sq_root_a),
        .root_b    (sq_root_b)
    );

    // saturate to the output width (only bites for large FRAC_BITS)
    always_comb
    begin
        ext_a = EXT_W'(sq_root_a);
        ext_b = EXT_W'(sq_root_b);
        dist_first_next  = (ext_a > EXT_W'(rtcd_pkg::OUT_MAX)) ? rtcd_pkg::OUT_MAX
                                                                : ext_a[OUT_W-1:0];
        dist_second_next = (ext_b > EXT_W'(rtcd_pkg::OUT_MAX)) ? rtcd_pkg::OUT_MAX
                                                                : ext_b[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_first_reg  <= dist_first_next;
            dist_second_reg <= dist_second_next;
            final_reg       <= sq_final;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dist_first  = dist_first_reg;
    assign dist_second = dist_second_reg;
    assign final_out   = final_reg;

    // a frozen pipeline keeps the word leaving the square root unit
    a_freeze_holds_root: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(sq_valid) && $stable(sq_root_a) && $stable(sq_root_b)))
        else $error("square root stage moved while pipeline held");

    // an output word only appears when the square root unit had one ready
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(sq_valid))
        else $error("output word appeared without a source word");

    // input is held back only while a finished word waits at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no waiting output word");

endmodule

`default_nettype wire

@@ sv/rtcd_sumsq.sv @@
// rtcd_sumsq: three-stage squared distance of a pixel to two centroids
// depends on rtcd_pkg (rgb_t, CH_W, SUM_W)
`default_nettype none

module rtcd_sumsq
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic                      in_final,
    input  wire rtcd_pkg::rgb_t            pixel,
    input  wire rtcd_pkg::rgb_t            cent_a,
    input  wire rtcd_pkg::rgb_t            cent_b,
    output logic                           out_valid,
    output logic                           out_final,
    output logic [rtcd_pkg::SUM_W-1:0]     sum_a,
    output logic [rtcd_pkg::SUM_W-1:0]     sum_b
);

    localparam int CH_W  = rtcd_pkg::CH_W;
    localparam int SQ_W  = 2 * CH_W;
    localparam int SUM_W = rtcd_pkg::SUM_W;

    logic [2:0][CH_W-1:0] pix_ch;
    logic [1:0][2:0][CH_W-1:0] cent_ch;

    // stage 1: absolute channel differences
    logic [1:0][2:0][CH_W-1:0] diff_next, diff_reg;
    // stage 2: squares
    logic [1:0][2:0][SQ_W-1:0] sq_next, sq_reg;
    // stage 3: sums
    logic [1:0][SUM_W-1:0]     sum_next, sum_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic f1_reg, f2_reg, f3_reg;

    assign pix_ch     = pixel;
    assign cent_ch[0] = cent_a;
    assign cent_ch[1] = cent_b;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff_next[c][i] = (pix_ch[i] >= cent_ch[c][i]) ? (pix_ch[i] - cent_ch[c][i])
                                                               : (cent_ch[c][i] - pix_ch[i]);
                sq_next[c][i]   = SQ_W'(diff_reg[c][i]) * SQ_W'(diff_reg[c][i]);
            end
            sum_next[c] = SUM_W'(sq_reg[c][0]) + SUM_W'(sq_reg[c][1]) + SUM_W'(sq_reg[c][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            sq_reg   <= sq_next;
            sum_reg  <= sum_next;
            f1_reg   <= in_final;
            f2_reg   <= f1_reg;
            f3_reg   <= f2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_final = f3_reg;
    assign sum_a     = sum_reg[0];
    assign sum_b     = sum_reg[1];

endmodule

`default_nettype wire

@@ sv/rtcd_isqrt.sv @@
// rtcd_isqrt: two-lane pipelined integer square root, one root bit per stage
// no package dependency; width set by ROOT_W
`default_nettype none

module rtcd_isqrt
#(
    parameter int ROOT_W = 17
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic                  in_final,
    input  wire logic [2*ROOT_W-1:0]   rad_a,
    input  wire logic [2*ROOT_W-1:0]   rad_b,
    output logic                       out_valid,
    output logic                       out_final,
    output logic [ROOT_W-1:0]          root_a,
    output logic [ROOT_W-1:0]          root_b
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [1:0][RAD_W-1:0]  rad_reg  [0:ROOT_W-1];
    logic [1:0][REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [1:0][ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic                   vld_reg  [0:ROOT_W-1];
    logic                   fin_reg  [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic [1:0][RAD_W-1:0]  rad_in;
            logic [1:0][REM_W-1:0]  rem_in;
            logic [1:0][ROOT_W-1:0] root_in;
            logic                   vld_in;
            logic                   fin_in;
            logic [1:0][REM_W-1:0]  rem_sh;
            logic [1:0][REM_W-1:0]  trial;
            logic [1:0][RAD_W-1:0]  rad_next;
            logic [1:0][REM_W-1:0]  rem_next;
            logic [1:0][ROOT_W-1:0] root_next;

            if (k == 0)
            begin : g_first
                assign rad_in[0] = rad_a;
                assign rad_in[1] = rad_b;
                assign rem_in    = '0;
                assign root_in   = '0;
                assign vld_in    = in_valid;
                assign fin_in    = in_final;
            end
            else
            begin : g_next
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign vld_in  = vld_reg[k-1];
                assign fin_in  = fin_reg[k-1];
            end

            // bring down two radicand bits, try root*4+1
            always_comb
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_sh[l]   = {rem_in[l][REM_W-3:0], rad_in[l][RAD_W-1 -: 2]};
                    trial[l]    = {root_in[l], 2'b01};
                    rad_next[l] = rad_in[l] << 2;
                    if (rem_sh[l] >= trial[l])
                    begin
                        rem_next[l]  = rem_sh[l] - trial[l];
                        root_next[l] = {root_in[l][ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l]  = rem_sh[l];
                        root_next[l] = {root_in[l][ROOT_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= rad_next;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    fin_reg[k]  <= fin_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_final = fin_reg[ROOT_W-1];
    assign root_a    = root_reg[ROOT_W-1][0];
    assign root_b    = root_reg[ROOT_W-1][1];

endmodule

`default_nettype wire
